// ===== rtl/core/mtat_pkg.sv =====
// Package for the multi-turn angle tracker: field widths, reset values,
// register indexes, command codes and the structure handed to the averager.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtat_pkg;

  // Field widths
  localparam int unsigned ANGLE_W    = 12;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned POS_OUT_W  = 32;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 40;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Parameter defaults
  localparam int unsigned CHANNELS_DEF  = 8;
  localparam int unsigned WINDOW_DEF    = 4;
  localparam int unsigned TURN_BITS_DEF = 20;

  // Register reset values
  localparam logic               WRAP_RST = 1'b1;
  localparam logic [ANGLE_W-1:0] THR_RST  = 12'd3700;

  // Pattern folded into every position and into every average
  localparam logic [1:0] NOISE_XOR = 2'b11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 1'b1;

  // Command codes
  localparam logic CMD_PRIME  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Closed window handed from the tracker to the averager
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [SUM_W-1:0] sum;
  } sum_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtat_track.sv =====
// Per-channel tracker: input register, configuration registers and the
// per-channel state with its read-modify-write. Uses mtat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtat_track import mtat_pkg::*; #(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned WINDOW    = WINDOW_DEF,
  parameter int unsigned TURN_BITS = TURN_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic                  s_cmd_i,
  input  wire logic [CH_W-1:0]       s_ch_i,
  input  wire logic [ANGLE_W-1:0]    s_angle_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       sum_valid_o,
  input  wire logic                  sum_ready_i,
  output sum_item_t                  sum_o
);

  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned FILL_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned POS_W  = TURN_BITS + ANGLE_W;

  logic               wrap_q;
  logic [ANGLE_W-1:0] thr_q;

  logic               in_vld_q;
  logic               in_cmd_q;
  logic [CH_W-1:0]    in_ch_q;
  logic [ANGLE_W-1:0] in_ang_q;

  logic [ANGLE_W-1:0]   last_q [CHANNELS];
  logic [TURN_BITS-1:0] turn_q [CHANNELS];
  logic [SUM_W-1:0]     sum_q  [CHANNELS];
  logic [FILL_W-1:0]    fill_q [CHANNELS];

  logic                 s_fire;
  logic                 ch_ok;
  logic [IDX_W-1:0]     rd_idx;
  logic [ANGLE_W-1:0]   prev;
  logic                 up;
  logic [ANGLE_W-1:0]   mag;
  logic                 jump;
  logic [TURN_BITS-1:0] turn_cur;
  logic [TURN_BITS-1:0] turn_d;
  logic [POS_W-1:0]     pos_full;
  logic [SUM_W-1:0]     pos;
  logic [SUM_W-1:0]     sum_d;
  logic [FILL_W-1:0]    fill_cur;
  logic                 closes;
  logic                 is_sample;
  logic                 needs_out;
  logic                 in_done;
  logic                 wr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= WRAP_RST;
      thr_q  <= THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WRAP_ENABLE:    wrap_q <= cfg_data_i[0];
        CFG_JUMP_THRESHOLD: thr_q  <= cfg_data_i[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  assign s_fire = s_valid_i & s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (in_done) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cmd_q <= s_cmd_i;
      in_ch_q  <= s_ch_i;
      in_ang_q <= s_angle_i;
    end
  end

  // State read and update for the held item
  assign ch_ok    = {1'b0, in_ch_q} < (CH_W + 1)'(CHANNELS);
  assign rd_idx   = ch_ok ? in_ch_q[IDX_W-1:0] : '0;
  assign prev     = last_q[rd_idx];
  assign turn_cur = turn_q[rd_idx];
  assign fill_cur = fill_q[rd_idx];

  assign up   = prev > in_ang_q;
  assign mag  = up ? (prev - in_ang_q) : (in_ang_q - prev);
  assign jump = wrap_q & (mag > thr_q);

  always_comb begin
    turn_d = turn_cur;
    if (jump) begin
      turn_d = up ? (turn_cur + 1'b1) : (turn_cur - 1'b1);
    end
  end

  // With wrapping on, position is the angle under the sign-extended turn count; else the bare angle
  assign pos_full = {turn_d, in_ang_q};
  assign pos      = wrap_q ? SUM_W'($signed(pos_full)) : SUM_W'(in_ang_q);
  assign sum_d    = sum_q[rd_idx] + (pos ^ SUM_W'(NOISE_XOR));

  assign closes    = fill_cur == FILL_W'(WINDOW - 1);
  assign is_sample = in_cmd_q == CMD_SAMPLE;
  assign needs_out = ch_ok & is_sample & closes;

  // The item completes unless its window closes and the averager is full
  assign in_done   = in_vld_q & (~needs_out | sum_ready_i);
  assign s_ready_o = ~in_vld_q | in_done;
  assign wr        = in_done & ch_ok;

  assign sum_valid_o = in_vld_q & needs_out;
  assign sum_o.ch    = in_ch_q;
  assign sum_o.sum   = sum_d;

  // Per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        last_q[i] <= '0;
        turn_q[i] <= '0;
        sum_q[i]  <= '0;
        fill_q[i] <= '0;
      end
    end else if (wr) begin
      last_q[rd_idx] <= in_ang_q;
      if (!is_sample) begin
        turn_q[rd_idx] <= '0;
        sum_q[rd_idx]  <= '0;
        fill_q[rd_idx] <= '0;
      end else begin
        turn_q[rd_idx] <= turn_d;
        sum_q[rd_idx]  <= closes ? '0 : sum_d;
        fill_q[rd_idx] <= closes ? '0 : (fill_cur + 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mtat_avg.sv =====
// Window averager: signed 40-bit sum divided by the constant WINDOW through
// a reciprocal multiply split into partial products, then the output register.
// Uses mtat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtat_avg import mtat_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 sum_valid_i,
  output logic                      sum_ready_o,
  input  wire sum_item_t            sum_i,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output logic [CH_W-1:0]           m_ch_o,
  output logic [POS_OUT_W-1:0]      m_pos_o
);

  // floor(n / WINDOW) == (n * M) >> SH for all n < 2^SUM_W
  localparam int unsigned L      = $clog2(WINDOW);
  localparam int unsigned SH     = SUM_W + L;
  localparam int unsigned MW     = SUM_W + 2;
  localparam logic [63:0] M_FULL =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] M    = M_FULL[MW-1:0];

  localparam int unsigned A_LO_W = SUM_W / 2;
  localparam int unsigned A_HI_W = SUM_W - A_LO_W;
  localparam int unsigned K_LO_W = MW / 2;
  localparam int unsigned K_HI_W = MW - K_LO_W;
  localparam int unsigned FULL_W = (SH > MW) ? (SH + SUM_W) : (MW + SUM_W);

  localparam logic [K_LO_W-1:0] K_LO = M[K_LO_W-1:0];
  localparam logic [K_HI_W-1:0] K_HI = M[MW-1:K_LO_W];

  // Stage valids
  logic v0_q, v1_q, v2_q, v3_q, v4_q, out_vld_q;
  logic r0, r1, r2, r3, r4, r_out;

  // Stage payloads
  logic [CH_W-1:0]  ch0_q, ch1_q, ch2_q, ch3_q, ch4_q;
  logic [SUM_W-1:0] sum0_q;
  logic             neg1_q, neg2_q, neg3_q, neg4_q;
  logic [SUM_W-1:0] mag1_q;
  logic [A_LO_W+K_LO_W-1:0] p_ll2_q;
  logic [A_LO_W+K_HI_W-1:0] p_lh2_q;
  logic [A_HI_W+K_LO_W-1:0] p_hl2_q;
  logic [A_HI_W+K_HI_W-1:0] p_hh2_q;
  logic [FULL_W-1:0] hh3_q, cross3_q, ll3_q;
  logic [SUM_W-1:0]  quot4_q;
  logic [CH_W-1:0]      out_ch_q;
  logic [POS_OUT_W-1:0] out_pos_q;

  logic [FULL_W-1:0] full;
  logic [SUM_W-1:0]  signed_q;

  // Bubble-collapsing ready chain
  assign r_out       = ~out_vld_q | m_ready_i;
  assign r4          = ~v4_q | r_out;
  assign r3          = ~v3_q | r4;
  assign r2          = ~v2_q | r3;
  assign r1          = ~v1_q | r2;
  assign r0          = ~v0_q | r1;
  assign sum_ready_o = r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (r0)    v0_q      <= sum_valid_i;
      if (r1)    v1_q      <= v0_q;
      if (r2)    v2_q      <= v1_q;
      if (r3)    v3_q      <= v2_q;
      if (r4)    v4_q      <= v3_q;
      if (r_out) out_vld_q <= v4_q;
    end
  end

  // Stage 0: capture the closed window
  always_ff @(posedge clk_i) begin
    if (r0) begin
      ch0_q  <= sum_i.ch;
      sum0_q <= sum_i.sum;
    end
  end

  // Stage 1: sign and magnitude
  always_ff @(posedge clk_i) begin
    if (r1) begin
      ch1_q  <= ch0_q;
      neg1_q <= sum0_q[SUM_W-1];
      mag1_q <= sum0_q[SUM_W-1] ? (~sum0_q + 1'b1) : sum0_q;
    end
  end

  // Stage 2: four partial products of magnitude and reciprocal
  always_ff @(posedge clk_i) begin
    if (r2) begin
      ch2_q   <= ch1_q;
      neg2_q  <= neg1_q;
      p_ll2_q <= (A_LO_W+K_LO_W)'(mag1_q[A_LO_W-1:0]) * (A_LO_W+K_LO_W)'(K_LO);
      p_lh2_q <= (A_LO_W+K_HI_W)'(mag1_q[A_LO_W-1:0]) * (A_LO_W+K_HI_W)'(K_HI);
      p_hl2_q <= (A_HI_W+K_LO_W)'(mag1_q[SUM_W-1:A_LO_W]) * (A_HI_W+K_LO_W)'(K_LO);
      p_hh2_q <= (A_HI_W+K_HI_W)'(mag1_q[SUM_W-1:A_LO_W]) * (A_HI_W+K_HI_W)'(K_HI);
    end
  end

  // Stage 3: align the products, fold the two cross terms
  always_ff @(posedge clk_i) begin
    if (r3) begin
      ch3_q    <= ch2_q;
      neg3_q   <= neg2_q;
      hh3_q    <= FULL_W'(p_hh2_q) << (A_LO_W + K_LO_W);
      cross3_q <= (FULL_W'(p_lh2_q) << K_LO_W) + (FULL_W'(p_hl2_q) << A_LO_W);
      ll3_q    <= FULL_W'(p_ll2_q);
    end
  end

  // Stage 4: full product and quotient
  assign full = hh3_q + cross3_q + ll3_q;

  always_ff @(posedge clk_i) begin
    if (r4) begin
      ch4_q   <= ch3_q;
      neg4_q  <= neg3_q;
      quot4_q <= full[SH +: SUM_W];
    end
  end

  // Output register: restore the sign, fold the pattern, keep 32 bits
  assign signed_q = neg4_q ? (~quot4_q + 1'b1) : quot4_q;

  always_ff @(posedge clk_i) begin
    if (r_out) begin
      out_ch_q  <= ch4_q;
      out_pos_q <= signed_q[POS_OUT_W-1:0] ^ POS_OUT_W'(NOISE_XOR);
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_ch_o    = out_ch_q;
  assign m_pos_o   = out_pos_q;

endmodule

`default_nettype wire

// ===== rtl/core/multi_turn_angle_tracker.sv =====
// Top level of the multi-turn angle tracker: stream ports, tracker and
// averager. Uses mtat_pkg, mtat_track and mtat_avg.
`timescale 1ns / 1ps
`default_nettype none

// Tracks up to CHANNELS 12-bit absolute encoders as multi-turn positions and
// reports one window-averaged position per channel every WINDOW samples.
// A prime transfer (tuser = 0) loads the first angle and clears the channel;
// sample transfers (tuser = 1) unwrap and accumulate. Channels at or above
// CHANNELS are dropped. One input transfer is taken every cycle unless a closing
// window waits on a full averager; each item is a read-modify-write of its channel's
// state registers. A closing window's sum goes through a six-stage divide-by-WINDOW
// pipeline (reciprocal multiply) to m_axis. After reset every channel reads as primed
// at angle zero; wrapping is on and the jump threshold is 3700. Configuration is to
// be written by the user only while the block idles; the block does not enforce it.
module multi_turn_angle_tracker import mtat_pkg::*; #(
  parameter int unsigned CHANNELS  = CHANNELS_DEF,
  parameter int unsigned WINDOW    = WINDOW_DEF,
  parameter int unsigned TURN_BITS = TURN_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // channel[2:0], angle[14:3]
  input  wire logic                  s_axis_tuser,   // command
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,   // out_channel[2:0], position[34:3]
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PAD_W = M_TDATA_W - CH_W - POS_OUT_W;

  logic                 sum_valid;
  logic                 sum_ready;
  sum_item_t            sum_item;
  logic [CH_W-1:0]      out_ch;
  logic [POS_OUT_W-1:0] out_pos;

  mtat_track #(
    .CHANNELS  (CHANNELS),
    .WINDOW    (WINDOW),
    .TURN_BITS (TURN_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_cmd_i     (s_axis_tuser),
    .s_ch_i      (s_axis_tdata[CH_W-1:0]),
    .s_angle_i   (s_axis_tdata[CH_W +: ANGLE_W]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_o       (sum_item)
  );

  mtat_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .sum_i       (sum_item),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_ch_o      (out_ch),
    .m_pos_o     (out_pos)
  );

  // Result packing, padded to whole bytes
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_pos, out_ch};

endmodule

`default_nettype wire

// ===== rtl/core/mtat_checker.sv =====
// Port-level checks for the multi-turn angle tracker, bound to the top level.
// Uses mtat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtat_checker import mtat_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A result is withdrawn only after its transfer
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid) |-> $past(m_axis_tready))
    else $error("result dropped without transfer");

  // Only existing channels report
  a_out_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[CH_W-1:0]} < (CH_W + 1)'(CHANNELS)))
    else $error("result for a channel that does not exist");

  // With the sink open the input never stalls
  a_in_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output sink ready");

endmodule

bind multi_turn_angle_tracker mtat_checker #(
  .CHANNELS (CHANNELS)
) u_mtat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for multi_turn_angle_tracker: drives prime and sample
// transfers, predicts the window averages and checks every result transfer.
// Depends on mtat_pkg and the multi_turn_angle_tracker RTL.
`timescale 1ns / 1ps

module tb_top;
  import mtat_pkg::*;

  localparam int unsigned NCH        = CHANNELS_DEF;
  localparam int unsigned WIN        = WINDOW_DEF;
  localparam int unsigned TURN_W     = TURN_BITS_DEF;
  localparam int unsigned SETTLE     = 20;    // pipeline is six deep, allow margin
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned PER_PHASE  = 105;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned PAUSE_PH   = 1;
  localparam int unsigned HOLD_PH    = 2;
  localparam int unsigned CALM_PH    = 3;

  typedef struct packed {
    logic [CH_W-1:0]      ch;
    logic [POS_OUT_W-1:0] pos;
  } avg_t;

  // One directed stimulus line; pos is only used when typed is set
  typedef struct packed {
    logic                 cmd;
    logic [CH_W-1:0]      ch;
    logic [ANGLE_W-1:0]   ang;
    logic                 typed;
    logic [POS_OUT_W-1:0] pos;
  } row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;   // channel[2:0], angle[14:3]
  logic                  s_axis_tuser  = 1'b0; // command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;         // out_channel[2:0], position[34:3]
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Mirror of the block's configuration and per-channel state
  logic               wrap_on = WRAP_RST;
  logic [ANGLE_W-1:0] jump_thr = THR_RST;
  logic [ANGLE_W-1:0] last_ang [NCH] = '{default: '0};
  logic [TURN_W-1:0]  turns    [NCH] = '{default: '0};
  logic [SUM_W-1:0]   acc      [NCH] = '{default: '0};
  int unsigned        fill     [NCH] = '{default: 0};

  avg_t        pending_avgs [$];
  int unsigned mismatches = 0;
  int unsigned phase_no   = 0;
  wire         calm       = (phase_no == CALM_PH);

  multi_turn_angle_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Unwrap one angle and accumulate; returns 1 when the window closes
  function automatic bit track_encoder(input logic cmd, input logic [CH_W-1:0] ch,
                                       input logic [ANGLE_W-1:0] ang, output avg_t res);
    logic [ANGLE_W-1:0] prev, mag;
    logic [SUM_W-1:0]   p, s, q;
    bit                 up;
    res = '0;
    if (ch >= NCH) return 1'b0;
    if (cmd == CMD_PRIME) begin
      last_ang[ch] = ang;
      turns[ch]    = '0;
      acc[ch]      = '0;
      fill[ch]     = 0;
      return 1'b0;
    end
    prev         = last_ang[ch];
    up           = prev > ang;
    mag          = up ? prev - ang : ang - prev;
    last_ang[ch] = ang;
    p            = SUM_W'(ang);
    if (wrap_on) begin
      if (mag > jump_thr) turns[ch] = up ? turns[ch] + 1'b1 : turns[ch] - 1'b1;
      p = p + ({{(SUM_W-TURN_W){turns[ch][TURN_W-1]}}, turns[ch]} << ANGLE_W);
    end
    acc[ch] = acc[ch] + (p ^ SUM_W'(NOISE_XOR));
    fill[ch]++;
    if (fill[ch] < WIN) return 1'b0;
    // average truncates toward zero
    s = acc[ch];
    if (s[SUM_W-1]) q = -((-s) / WIN);
    else            q = s / WIN;
    res.ch   = ch;
    res.pos  = q[POS_OUT_W-1:0] ^ POS_OUT_W'(NOISE_XOR);
    acc[ch]  = '0;
    fill[ch] = 0;
    return 1'b1;
  endfunction

  // Mostly plausible motion: small steps, jumps across the zero point, some noise
  function automatic logic [ANGLE_W-1:0] next_angle(input logic [CH_W-1:0] ch);
    logic [ANGLE_W-1:0] delta;
    delta = ANGLE_W'($urandom_range(300));
    case ($urandom_range(9))
      0, 1, 2:       return ANGLE_W'($urandom_range(4095));
      3, 4, 5, 6, 7: return $urandom_range(1) ? last_ang[ch] + delta : last_ang[ch] - delta;
      default:       return $urandom_range(1) ? ANGLE_W'($urandom_range(40))
                                              : ANGLE_W'(4095 - $urandom_range(40));
    endcase
  endfunction

  // Offer one item, wait for the transfer, then book the expected average
  task automatic send_item(input logic cmd, input logic [CH_W-1:0] ch,
                           input logic [ANGLE_W-1:0] ang, input logic typed,
                           input logic [POS_OUT_W-1:0] typed_pos);
    avg_t res;
    if (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 31);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({ang, ch});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (track_encoder(cmd, ch, ang, res)) begin
      if (typed) res.pos = typed_pos;
      pending_avgs.push_back(res);
    end
  endtask

  // Stop offering, let every booked average arrive and the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic wrap, input logic [ANGLE_W-1:0] thr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WRAP_ENABLE;
    cfg_data_i <= CFG_DATA_W'(wrap);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_JUMP_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    wrap_on    = wrap;
    jump_thr   = thr;
  endtask

  // Result side: random back-pressure, one long hold-off, calm in one phase
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (phase_no == HOLD_PH && !held) begin
        held      = 1'b1;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  // Compare each result transfer with the oldest booked average
  always @(posedge clk_i) begin : result_check
    avg_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_avgs.size() == 0) begin
        $error("unexpected result: out_channel %0d position %0d",
               m_axis_tdata[CH_W-1:0], $signed(m_axis_tdata[CH_W +: POS_OUT_W]));
        mismatches++;
      end else begin
        want = pending_avgs.pop_front();
        if (m_axis_tdata[CH_W-1:0] !== want.ch) begin
          $error("out_channel mismatch: expected %0d, actual %0d",
                 want.ch, m_axis_tdata[CH_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[CH_W +: POS_OUT_W] !== want.pos) begin
          $error("position mismatch: expected %0d, actual %0d",
                 $signed(want.pos), $signed(m_axis_tdata[CH_W +: POS_OUT_W]));
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t               dir_rows [0:23];
    logic [ANGLE_W-1:0] thr_v;
    logic [CH_W-1:0]    ch;
    logic               cmd;
    dir_rows = '{
      // channels come out of reset primed at angle zero
      '{CMD_SAMPLE, 3'd0, 12'd0,    1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd0, 12'd0,    1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd0, 12'd0,    1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd0, 12'd0,    1'b1, 32'd0},
      // top channel, top angle, standing still
      '{CMD_PRIME,  3'd7, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd7, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd7, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd7, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd7, 12'd4095, 1'b1, 32'd4095},
      // forward across zero and back again
      '{CMD_PRIME,  3'd3, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd3, 12'd0,    1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd3, 12'd100,  1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd3, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd3, 12'd0,    1'b0, 32'd0},
      // backwards below zero: negative positions
      '{CMD_PRIME,  3'd5, 12'd0,    1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd5, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd5, 12'd4000, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd5, 12'd4095, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd5, 12'd2048, 1'b0, 32'd0},
      // jump exactly at the threshold, then one above it
      '{CMD_PRIME,  3'd2, 12'd3700, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd2, 12'd0,    1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd2, 12'd3701, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd2, 12'd3701, 1'b0, 32'd0},
      '{CMD_SAMPLE, 3'd2, 12'd0,    1'b0, 32'd0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].ang,
                dir_rows[i].typed, dir_rows[i].pos);

    // Random phases, each under its own register setting
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain();
      case (ph)
        1, 2:    thr_v = '0;
        3:       thr_v = '1;
        4:       thr_v = ANGLE_W'($urandom_range(4095));
        default: thr_v = THR_RST;
      endcase
      set_config(ph != 1, thr_v);
      phase_no = ph;
      for (int i = 0; i < PER_PHASE; i++) begin
        // sender pause until every booked average has been delivered
        if (ph == PAUSE_PH && i == PER_PHASE / 2) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (pending_avgs.size() != 0);
        end
        ch  = CH_W'($urandom_range(7));
        cmd = ($urandom_range(99) < 8) ? CMD_PRIME : CMD_SAMPLE;
        send_item(cmd, ch, next_angle(ch), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mtat_pkg.sv
rtl/core/mtat_track.sv
rtl/core/mtat_avg.sv
rtl/core/multi_turn_angle_tracker.sv
rtl/core/mtat_checker.sv
test/tb_top.sv
